FILE: design/rgbled_pkg.sv
// ----------------------------------------------------------------------------
// rgbled_pkg
// Shared types, codes and constants of the RGB status LED pattern engine.
// ----------------------------------------------------------------------------
package rgbled_pkg;

  // Command codes carried by the op field.
  typedef enum logic [2:0] {
    OP_TICK        = 3'd0,
    OP_SET_PATTERN = 3'd1,
    OP_FLASH_PAT   = 3'd2,
    OP_SET_COLOR   = 3'd3,
    OP_FLASH_COLOR = 3'd4
  } op_t;

  // Pattern codes.
  typedef enum logic [2:0] {
    PAT_IDLE       = 3'd0,
    PAT_SCANNING   = 3'd1,
    PAT_CONNECTING = 3'd2,
    PAT_CONNECTED  = 3'd3,
    PAT_RX         = 3'd4,
    PAT_TX         = 3'd5,
    PAT_EMERGENCY  = 3'd6,
    PAT_ERROR      = 3'd7
  } pattern_t;

  // Color codes.
  typedef enum logic [2:0] {
    COL_OFF     = 3'd0,
    COL_RED     = 3'd1,
    COL_GREEN   = 3'd2,
    COL_BLUE    = 3'd3,
    COL_YELLOW  = 3'd4,
    COL_CYAN    = 3'd5,
    COL_MAGENTA = 3'd6,
    COL_WHITE   = 3'd7
  } color_t;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_REFRESH_MS      = 2'd0,
    REG_CONNECT_HALF_MS = 2'd1,
    REG_ALERT_HALF_MS   = 2'd2,
    REG_IDLE_BLUE       = 2'd3
  } reg_idx_t;

  localparam int unsigned FLASH_W = 24;
  localparam int unsigned MS_W    = 10;
  localparam int unsigned PHASE_W = MS_W + 1;

  localparam logic [MS_W-1:0]    REFRESH_MS_RST      = 10'd20;
  localparam logic [MS_W-1:0]    CONNECT_HALF_MS_RST = 10'd250;
  localparam logic [MS_W-1:0]    ALERT_HALF_MS_RST   = 10'd200;
  localparam logic [7:0]         IDLE_BLUE_RST       = 8'd20;
  localparam logic [MS_W-1:0]    SINCE_MAX           = '1;
  localparam logic [FLASH_W-1:0] FLASH_MAX           = '1;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic [MS_W-1:0] refresh_ms;
    logic [MS_W-1:0] connect_half_ms;
    logic [MS_W-1:0] alert_half_ms;
    logic [7:0]      idle_blue;
  } cfg_t;

  // Control of the breathing phase for one accepted beat.
  typedef struct packed {
    logic advance;
    logic restart;
  } breathe_ctl_t;

  function automatic rgb_t color_lut(input color_t code);
    rgb_t c;
    c = '0;
    case (code)
      COL_OFF:     c = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
      COL_RED:     c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
      COL_GREEN:   c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
      COL_BLUE:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
      COL_YELLOW:  c = '{r: 8'd255, g: 8'd255, b: 8'd0};
      COL_CYAN:    c = '{r: 8'd0,   g: 8'd255, b: 8'd255};
      COL_MAGENTA: c = '{r: 8'd255, g: 8'd0,   b: 8'd255};
      default:     c = '{r: 8'd255, g: 8'd255, b: 8'd255};
    endcase
    return c;
  endfunction

endpackage

FILE: design/rgb_status_led_pattern_engine_top.sv
// ----------------------------------------------------------------------------
// rgb_status_led_pattern_engine_top
// RGB status LED pattern engine: millisecond ticks and commands in, one
// color result per beat out.
// ----------------------------------------------------------------------------
// The engine takes one command or tick beat per clock and returns exactly one
// result beat for each, in the cycle after acceptance, from an output register;
// a new beat is accepted in the same cycle that the previous result is taken.
// All state updates for a beat happen in a single pass of logic between the
// input handshake and the state and result registers. The breathing level
// comes from a synchronous ROM of BREATHE_PERIOD entries that is always read
// one tick ahead, so its read never delays a result. There is no clearing
// pass after reset. Configuration writes are meant for idle periods only.
module rgb_status_led_pattern_engine_top #(
  parameter int unsigned BREATHE_PERIOD = 2000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [2:0]  pattern_code,
  input  logic [2:0]  color_code,
  input  logic [23:0] flash_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  led_r,
  output logic [7:0]  led_g,
  output logic [7:0]  led_b,
  output logic        refreshed,
  output logic        flash_on,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned MS_W    = rgbled_pkg::MS_W;
  localparam int unsigned PHASE_W = rgbled_pkg::PHASE_W;
  localparam int unsigned FLASH_W = rgbled_pkg::FLASH_W;

  rgbled_pkg::cfg_t         cfg;
  rgbled_pkg::breathe_ctl_t bctl;
  logic [7:0]               breathe_lvl;
  logic                     accept;

  rgbled_pkg::pattern_t base_pattern, base_pattern_next;
  rgbled_pkg::pattern_t flash_pattern_code, flash_pattern_code_next;
  logic                 flash_active, flash_active_next;
  logic                 flash_holds_color, flash_holds_color_next;
  logic [FLASH_W-1:0]   flash_elapsed, flash_elapsed_next;
  logic [FLASH_W-1:0]   flash_length, flash_length_next;
  logic [MS_W-1:0]      since_refresh, since_refresh_next;
  logic [PHASE_W-1:0]   connect_phase, connect_phase_next;
  logic [PHASE_W-1:0]   alert_phase, alert_phase_next;
  rgbled_pkg::rgb_t     color, color_next;
  logic                 refreshed_next;

  logic [MS_W-1:0]      connect_half, alert_half;
  logic [PHASE_W-1:0]   connect_period, alert_period;
  logic [MS_W-1:0]      since_inc;
  rgbled_pkg::pattern_t show_pattern;

  assign accept   = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  rgbled_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign bctl.advance = (rgbled_pkg::op_t'(op) == rgbled_pkg::OP_TICK);
  assign bctl.restart = (rgbled_pkg::op_t'(op) == rgbled_pkg::OP_SET_PATTERN) &&
                        (rgbled_pkg::pattern_t'(pattern_code) != base_pattern);

  rgbled_breathe #(
    .BREATHE_PERIOD (BREATHE_PERIOD)
  ) u_breathe (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .ctl         (bctl),
    .level_ahead (breathe_lvl)
  );

  // A half period of zero behaves as one.
  assign connect_half   = (cfg.connect_half_ms == '0) ? MS_W'(1) : cfg.connect_half_ms;
  assign alert_half     = (cfg.alert_half_ms == '0) ? MS_W'(1) : cfg.alert_half_ms;
  assign connect_period = {connect_half, 1'b0};
  assign alert_period   = {alert_half, 1'b0};
  assign since_inc      = (since_refresh < rgbled_pkg::SINCE_MAX) ?
                          since_refresh + 1'b1 : since_refresh;

  function automatic logic [PHASE_W-1:0] phase_adv(input logic [PHASE_W-1:0] p,
                                                   input logic [PHASE_W-1:0] per);
    logic [PHASE_W:0] n;
    n = {1'b0, p} + 1'b1;
    return (n >= {1'b0, per}) ? '0 : n[PHASE_W-1:0];
  endfunction

  always_comb begin
    base_pattern_next       = base_pattern;
    flash_pattern_code_next = flash_pattern_code;
    flash_active_next       = flash_active;
    flash_holds_color_next  = flash_holds_color;
    flash_elapsed_next      = flash_elapsed;
    flash_length_next       = flash_length;
    since_refresh_next      = since_refresh;
    connect_phase_next      = connect_phase;
    alert_phase_next        = alert_phase;
    color_next              = color;
    refreshed_next          = 1'b0;
    show_pattern            = base_pattern;

    case (rgbled_pkg::op_t'(op))
      rgbled_pkg::OP_TICK: begin
        connect_phase_next = phase_adv(connect_phase, connect_period);
        alert_phase_next   = phase_adv(alert_phase, alert_period);
        if (flash_elapsed < rgbled_pkg::FLASH_MAX) begin
          flash_elapsed_next = flash_elapsed + 1'b1;
        end
        if (flash_active && (flash_elapsed_next >= flash_length)) begin
          flash_active_next      = 1'b0;
          flash_holds_color_next = 1'b0;
        end
        since_refresh_next = since_inc;
        if (since_inc >= cfg.refresh_ms) begin
          since_refresh_next = '0;
          // A running color flash keeps its color over the refresh slot.
          if (!(flash_active_next && flash_holds_color_next)) begin
            refreshed_next = 1'b1;
            show_pattern   = flash_active_next ? flash_pattern_code : base_pattern;
            case (show_pattern)
              rgbled_pkg::PAT_IDLE:
                color_next = '{r: 8'd0, g: 8'd0, b: cfg.idle_blue};
              rgbled_pkg::PAT_SCANNING:
                color_next = '{r: breathe_lvl, g: breathe_lvl, b: 8'd0};
              rgbled_pkg::PAT_CONNECTING:
                color_next = (connect_phase_next < PHASE_W'(connect_half)) ?
                             rgbled_pkg::color_lut(rgbled_pkg::COL_YELLOW) :
                             rgbled_pkg::color_lut(rgbled_pkg::COL_OFF);
              rgbled_pkg::PAT_CONNECTED:
                color_next = rgbled_pkg::color_lut(rgbled_pkg::COL_GREEN);
              rgbled_pkg::PAT_RX:
                color_next = rgbled_pkg::color_lut(rgbled_pkg::COL_BLUE);
              rgbled_pkg::PAT_TX:
                color_next = rgbled_pkg::color_lut(rgbled_pkg::COL_CYAN);
              rgbled_pkg::PAT_EMERGENCY:
                color_next = (alert_phase_next < PHASE_W'(alert_half)) ?
                             rgbled_pkg::color_lut(rgbled_pkg::COL_RED) :
                             rgbled_pkg::color_lut(rgbled_pkg::COL_OFF);
              default:
                color_next = rgbled_pkg::color_lut(rgbled_pkg::COL_RED);
            endcase
          end
        end
      end
      rgbled_pkg::OP_SET_PATTERN: begin
        if (bctl.restart) begin
          base_pattern_next  = rgbled_pkg::pattern_t'(pattern_code);
          connect_phase_next = '0;
          alert_phase_next   = '0;
        end
      end
      rgbled_pkg::OP_FLASH_PAT: begin
        flash_pattern_code_next = rgbled_pkg::pattern_t'(pattern_code);
        flash_length_next       = flash_ms;
        flash_elapsed_next      = '0;
        flash_active_next       = 1'b1;
        flash_holds_color_next  = 1'b0;
      end
      rgbled_pkg::OP_SET_COLOR: begin
        color_next = rgbled_pkg::color_lut(rgbled_pkg::color_t'(color_code));
      end
      rgbled_pkg::OP_FLASH_COLOR: begin
        color_next             = rgbled_pkg::color_lut(rgbled_pkg::color_t'(color_code));
        flash_length_next      = flash_ms;
        flash_elapsed_next     = '0;
        flash_active_next      = 1'b1;
        flash_holds_color_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_pattern       <= rgbled_pkg::PAT_IDLE;
      flash_pattern_code <= rgbled_pkg::PAT_IDLE;
      flash_active       <= 1'b0;
      flash_holds_color  <= 1'b0;
      flash_elapsed      <= '0;
      flash_length       <= '0;
      since_refresh      <= '0;
      connect_phase      <= '0;
      alert_phase        <= '0;
      color              <= '{r: 8'd0, g: 8'd0, b: rgbled_pkg::IDLE_BLUE_RST};
      refreshed          <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (accept) begin
        base_pattern       <= base_pattern_next;
        flash_pattern_code <= flash_pattern_code_next;
        flash_active       <= flash_active_next;
        flash_holds_color  <= flash_holds_color_next;
        flash_elapsed      <= flash_elapsed_next;
        flash_length       <= flash_length_next;
        since_refresh      <= since_refresh_next;
        connect_phase      <= connect_phase_next;
        alert_phase        <= alert_phase_next;
        color              <= color_next;
        refreshed          <= refreshed_next;
        out_valid          <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The result beat shows the state left by the last accepted beat.
  assign led_r    = color.r;
  assign led_g    = color.g;
  assign led_b    = color.b;
  assign flash_on = flash_active;

  a_cmd_no_refresh: assert property (@(posedge clk) disable iff (rst)
    accept && (op != rgbled_pkg::OP_TICK) |=> !refreshed)
    else $error("command beat reported a refresh");

  a_color_flash_on: assert property (@(posedge clk) disable iff (rst)
    accept && (op == rgbled_pkg::OP_FLASH_COLOR) |=> flash_on && flash_holds_color)
    else $error("color flash did not start");

  a_held_color: assert property (@(posedge clk) disable iff (rst)
    accept && flash_active && flash_holds_color && (op == rgbled_pkg::OP_TICK) &&
    flash_active_next |=> !refreshed && $stable(color))
    else $error("color changed during a color flash");

  a_accept_gives_beat: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

endmodule

FILE: design/rgbled_cfg.sv
// ----------------------------------------------------------------------------
// rgbled_cfg
// APB-style register file holding refresh interval, blink half periods and
// the idle blue level.
// ----------------------------------------------------------------------------
module rgbled_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output rgbled_pkg::cfg_t   cfg
);

  rgbled_pkg::reg_idx_t idx;
  logic                 wr;

  assign idx    = rgbled_pkg::reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.refresh_ms      <= rgbled_pkg::REFRESH_MS_RST;
      cfg.connect_half_ms <= rgbled_pkg::CONNECT_HALF_MS_RST;
      cfg.alert_half_ms   <= rgbled_pkg::ALERT_HALF_MS_RST;
      cfg.idle_blue       <= rgbled_pkg::IDLE_BLUE_RST;
    end else if (wr) begin
      unique case (idx)
        rgbled_pkg::REG_REFRESH_MS:      cfg.refresh_ms      <= pwdata[9:0];
        rgbled_pkg::REG_CONNECT_HALF_MS: cfg.connect_half_ms <= pwdata[9:0];
        rgbled_pkg::REG_ALERT_HALF_MS:   cfg.alert_half_ms   <= pwdata[9:0];
        rgbled_pkg::REG_IDLE_BLUE:       cfg.idle_blue       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      rgbled_pkg::REG_REFRESH_MS:      prdata = 32'(cfg.refresh_ms);
      rgbled_pkg::REG_CONNECT_HALF_MS: prdata = 32'(cfg.connect_half_ms);
      rgbled_pkg::REG_ALERT_HALF_MS:   prdata = 32'(cfg.alert_half_ms);
      rgbled_pkg::REG_IDLE_BLUE:       prdata = 32'(cfg.idle_blue);
      default:                         prdata = '0;
    endcase
  end

endmodule

FILE: design/rgbled_breathe.sv
// ----------------------------------------------------------------------------
// rgbled_breathe
// Breathing phase counter with a synchronous sine ROM. The registered level
// is always the one for the phase that the next tick will reach.
// ----------------------------------------------------------------------------
module rgbled_breathe #(
  parameter int unsigned BREATHE_PERIOD = 2000
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  rgbled_pkg::breathe_ctl_t ctl,
  output logic [7:0]               level_ahead
);

  localparam int unsigned PW = (BREATHE_PERIOD > 1) ? $clog2(BREATHE_PERIOD) : 1;
  localparam logic [PW:0] PERIOD = (PW + 1)'(BREATHE_PERIOD);

  typedef logic [7:0] rom_t [BREATHE_PERIOD];

  // Level 155 +/- round(100*16q / (5P^2 - 4q)), q = t*(P-t), found by a
  // bitwise search so that no division is needed.
  function automatic rom_t build_rom();
    rom_t   r;
    longint p_l;
    longint u;
    longint t;
    longint q;
    longint den;
    longint lhs;
    longint m;
    logic   neg;
    p_l = longint'(BREATHE_PERIOD);
    for (int i = 0; i < BREATHE_PERIOD; i++) begin
      u   = 2 * longint'(i);
      neg = (u >= p_l);
      t   = neg ? u - p_l : u;
      q   = t * (p_l - t);
      den = 5 * p_l * p_l - 4 * q;
      lhs = 200 * 16 * q + den;
      m   = 0;
      for (int b = 6; b >= 0; b--) begin
        if ((m + (longint'(1) << b)) * 2 * den <= lhs) begin
          m = m + (longint'(1) << b);
        end
      end
      if (m > 100) begin
        m = 100;
      end
      r[i] = neg ? 8'(155 - m) : 8'(155 + m);
    end
    return r;
  endfunction

  localparam rom_t BREATHE_ROM = build_rom();

  logic [PW-1:0] phase;
  logic [PW-1:0] phase_next;
  logic [PW-1:0] phase_adv;
  logic [PW-1:0] ahead_addr;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p);
    logic [PW:0] n;
    n = {1'b0, p} + 1'b1;
    return (n >= PERIOD) ? '0 : n[PW-1:0];
  endfunction

  assign phase_adv = adv(phase);

  always_comb begin
    phase_next = phase;
    if (rst) begin
      phase_next = '0;
    end else if (accept && ctl.restart) begin
      phase_next = '0;
    end else if (accept && ctl.advance) begin
      phase_next = phase_adv;
    end
  end

  assign ahead_addr = adv(phase_next);

  always_ff @(posedge clk) begin
    phase <= phase_next;
  end

  always_ff @(posedge clk) begin
    level_ahead <= BREATHE_ROM[ahead_addr];
  end

endmodule

FILE: verif/rgb_led_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_result_checker
// Watches the command, result and register ports of the LED pattern engine,
// keeps its own copy of the engine state, and compares every result beat
// with the predicted color, refresh flag and flash flag.
// ----------------------------------------------------------------------------
module rgb_led_result_checker #(
  parameter int unsigned BREATHE_PERIOD = 2000
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        op,
  input  logic [2:0]        pattern_code,
  input  logic [2:0]        color_code,
  input  logic [23:0]       flash_ms,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        led_r,
  input  logic [7:0]        led_g,
  input  logic [7:0]        led_b,
  input  logic              refreshed,
  input  logic              flash_on,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output int unsigned       pending,
  output int unsigned       results_seen,
  output int unsigned       refresh_seen,
  output int unsigned       mismatches
);

  localparam int unsigned MS_W    = rgbled_pkg::MS_W;
  localparam int unsigned FLASH_W = rgbled_pkg::FLASH_W;

  typedef struct packed {
    rgbled_pkg::rgb_t color;
    logic             refreshed;
    logic             flash_on;
  } led_result_t;

  localparam rgbled_pkg::rgb_t COLOR_TABLE [0:7] = '{
    24'h000000, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFFFFFF
  };

  logic [MS_W-1:0]      refresh_cfg, connect_cfg, alert_cfg;
  logic [7:0]           idle_blue_cfg;
  rgbled_pkg::pattern_t base_pat, flash_pat;
  logic                 flashing, flash_is_color;
  logic [FLASH_W-1:0]   flash_age, flash_len;
  logic [MS_W-1:0]      ms_since_refresh;
  int unsigned          wave_ph, connect_ph, alert_ph;
  rgbled_pkg::rgb_t     shown;

  led_result_t  expected_leds [$];
  int unsigned  n_mismatch, n_results, n_refresh;

  function automatic int unsigned half_or_one(input logic [MS_W-1:0] h);
    return (h == '0) ? 1 : int'(h);
  endfunction

  function automatic int unsigned next_phase(input int unsigned ph, input int unsigned period);
    return (ph + 1 >= period) ? 0 : ph + 1;
  endfunction

  // Rounded sine approximation: 155 +/- 100 * 16q / (5P^2 - 4q).
  function automatic logic [7:0] wave_level(input int unsigned ph);
    longint unsigned per, u, t, q, num, den, m;
    logic neg;
    per = BREATHE_PERIOD;
    u   = 2 * longint'(ph);
    neg = (u >= per);
    t   = neg ? u - per : u;
    if (t > per) t = per;
    q   = t * (per - t);
    num = 16 * q;
    den = 5 * per * per - 4 * q;
    m   = (200 * num + den) / (2 * den);
    if (m > 100) m = 100;
    return neg ? 8'(155 - m) : 8'(155 + m);
  endfunction

  function automatic rgbled_pkg::rgb_t pattern_color(input rgbled_pkg::pattern_t p);
    rgbled_pkg::rgb_t c;
    logic [7:0] lv;
    lv = wave_level(wave_ph);
    case (p)
      rgbled_pkg::PAT_IDLE:       c = {16'd0, idle_blue_cfg};
      rgbled_pkg::PAT_SCANNING:   c = {lv, lv, 8'd0};
      rgbled_pkg::PAT_CONNECTING: c = (connect_ph < half_or_one(connect_cfg)) ?
                                      COLOR_TABLE[rgbled_pkg::COL_YELLOW] :
                                      COLOR_TABLE[rgbled_pkg::COL_OFF];
      rgbled_pkg::PAT_CONNECTED:  c = COLOR_TABLE[rgbled_pkg::COL_GREEN];
      rgbled_pkg::PAT_RX:         c = COLOR_TABLE[rgbled_pkg::COL_BLUE];
      rgbled_pkg::PAT_TX:         c = COLOR_TABLE[rgbled_pkg::COL_CYAN];
      rgbled_pkg::PAT_EMERGENCY:  c = (alert_ph < half_or_one(alert_cfg)) ?
                                      COLOR_TABLE[rgbled_pkg::COL_RED] :
                                      COLOR_TABLE[rgbled_pkg::COL_OFF];
      default:                    c = COLOR_TABLE[rgbled_pkg::COL_RED];
    endcase
    return c;
  endfunction

  function automatic led_result_t next_led_state(input logic [2:0] o,
                                                 input rgbled_pkg::pattern_t p,
                                                 input rgbled_pkg::color_t col,
                                                 input logic [23:0] ms);
    led_result_t r;
    logic did_refresh;
    did_refresh = 1'b0;
    case (o)
      rgbled_pkg::OP_TICK: begin
        wave_ph    = next_phase(wave_ph, BREATHE_PERIOD);
        connect_ph = next_phase(connect_ph, 2 * half_or_one(connect_cfg));
        alert_ph   = next_phase(alert_ph, 2 * half_or_one(alert_cfg));
        if (flash_age != rgbled_pkg::FLASH_MAX) flash_age++;
        if (flashing && flash_age >= flash_len) begin
          flashing       = 1'b0;
          flash_is_color = 1'b0;
        end
        if (ms_since_refresh != rgbled_pkg::SINCE_MAX) ms_since_refresh++;
        if (ms_since_refresh >= refresh_cfg) begin
          ms_since_refresh = '0;
          // A running color flash keeps its color through the refresh slot.
          if (!(flashing && flash_is_color)) begin
            shown       = pattern_color(flashing ? flash_pat : base_pat);
            did_refresh = 1'b1;
          end
        end
      end
      rgbled_pkg::OP_SET_PATTERN: begin
        if (p != base_pat) begin
          base_pat   = p;
          wave_ph    = 0;
          connect_ph = 0;
          alert_ph   = 0;
        end
      end
      rgbled_pkg::OP_FLASH_PAT: begin
        flash_pat      = p;
        flash_len      = ms;
        flash_age      = '0;
        flashing       = 1'b1;
        flash_is_color = 1'b0;
      end
      rgbled_pkg::OP_SET_COLOR: shown = COLOR_TABLE[col];
      rgbled_pkg::OP_FLASH_COLOR: begin
        shown          = COLOR_TABLE[col];
        flash_len      = ms;
        flash_age      = '0;
        flashing       = 1'b1;
        flash_is_color = 1'b1;
      end
      default: ;
    endcase
    r.color     = shown;
    r.refreshed = did_refresh;
    r.flash_on  = flashing;
    return r;
  endfunction

  always @(posedge clk) begin
    led_result_t want;
    led_result_t seen;
    if (rst) begin
      refresh_cfg      = rgbled_pkg::REFRESH_MS_RST;
      connect_cfg      = rgbled_pkg::CONNECT_HALF_MS_RST;
      alert_cfg        = rgbled_pkg::ALERT_HALF_MS_RST;
      idle_blue_cfg    = rgbled_pkg::IDLE_BLUE_RST;
      base_pat         = rgbled_pkg::PAT_IDLE;
      flash_pat        = rgbled_pkg::PAT_IDLE;
      flashing         = 1'b0;
      flash_is_color   = 1'b0;
      flash_age        = '0;
      flash_len        = '0;
      ms_since_refresh = '0;
      wave_ph          = 0;
      connect_ph       = 0;
      alert_ph         = 0;
      shown            = {16'd0, rgbled_pkg::IDLE_BLUE_RST};
      expected_leds.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (rgbled_pkg::reg_idx_t'(paddr[3:2]))
          rgbled_pkg::REG_REFRESH_MS:      refresh_cfg   = pwdata[MS_W-1:0];
          rgbled_pkg::REG_CONNECT_HALF_MS: connect_cfg   = pwdata[MS_W-1:0];
          rgbled_pkg::REG_ALERT_HALF_MS:   alert_cfg     = pwdata[MS_W-1:0];
          default:                         idle_blue_cfg = pwdata[7:0];
        endcase
      end
      // The result beat taken at this edge belongs to an earlier command, so it
      // is checked before this edge's command is predicted.
      if (out_valid && out_ready) begin
        seen.color     = {led_r, led_g, led_b};
        seen.refreshed = refreshed;
        seen.flash_on  = flash_on;
        if (expected_leds.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("%0t: result beat with nothing expected: rgb=(%0d,%0d,%0d)",
                     $realtime, led_r, led_g, led_b);
        end else begin
          want = expected_leds.pop_front();
          n_results++;
          if (want.refreshed) n_refresh++;
          if (want.color.r !== seen.color.r || want.color.g !== seen.color.g ||
              want.color.b !== seen.color.b || want.refreshed !== seen.refreshed ||
              want.flash_on !== seen.flash_on) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("%0t: result %0d expected rgb=(%0d,%0d,%0d) refreshed=%0b flash_on=%0b",
                       $realtime, n_results, want.color.r, want.color.g, want.color.b,
                       want.refreshed, want.flash_on);
              $display("    got rgb=(%0d,%0d,%0d) refreshed=%0b flash_on=%0b",
                       seen.color.r, seen.color.g, seen.color.b, seen.refreshed,
                       seen.flash_on);
            end
          end
        end
      end
      if (in_valid && in_ready)
        expected_leds.push_back(next_led_state(op, rgbled_pkg::pattern_t'(pattern_code),
                                               rgbled_pkg::color_t'(color_code), flash_ms));
    end
    pending      <= expected_leds.size();
    results_seen <= n_results;
    refresh_seen <= n_refresh;
    mismatches   <= n_mismatch;
  end

endmodule

FILE: verif/rgb_status_led_pattern_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_status_led_pattern_engine_top_tb
// Drives tick and command beats into the LED pattern engine under changing
// register settings and random back-pressure; a checker beside the engine
// predicts each result beat and counts mismatches.
// ----------------------------------------------------------------------------
module rgb_status_led_pattern_engine_top_tb;

  localparam int unsigned MS_W            = rgbled_pkg::MS_W;
  localparam int unsigned BREATHE_PERIOD  = 2000;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned BEATS_PER_PHASE = 100;
  localparam int unsigned SWEEP_TICKS     = 80;
  localparam logic [2:0]  OP_SPARE_LO     = 3'd5;
  localparam logic [2:0]  OP_SPARE_HI     = 3'd7;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [2:0]  op           = '0;
  logic [2:0]  pattern_code = '0;
  logic [2:0]  color_code   = '0;
  logic [23:0] flash_ms     = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [7:0]  led_r, led_g, led_b;
  logic        refreshed, flash_on;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [3:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned pending, results_seen, refresh_seen, mismatches;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_left    = 0;
  logic        stall_done    = 1'b0;
  int unsigned cycle_count   = 0;
  int unsigned spare_ops     = 0;
  int unsigned op_count [8]  = '{default: 0};

  always #5 clk = ~clk;

  rgb_status_led_pattern_engine_top #(
    .BREATHE_PERIOD(BREATHE_PERIOD)
  ) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .pattern_code(pattern_code), .color_code(color_code), .flash_ms(flash_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .led_r(led_r), .led_g(led_g), .led_b(led_b), .refreshed(refreshed), .flash_on(flash_on),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  rgb_led_result_checker #(
    .BREATHE_PERIOD(BREATHE_PERIOD)
  ) i_led_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .pattern_code(pattern_code), .color_code(color_code), .flash_ms(flash_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .led_r(led_r), .led_g(led_g), .led_b(led_b), .refreshed(refreshed), .flash_on(flash_on),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .pending(pending), .results_seen(results_seen), .refresh_seen(refresh_seen),
    .mismatches(mismatches)
  );

  // Result side: random stalls, plus one long hold-off early on so that the
  // engine backs up and drops in_ready while commands keep coming.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!stall_done && results_seen >= 40) begin
      stall_done <= 1'b1;
      stall_left <= 60;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("rgb_status_led_pattern_engine_top test failed");
    $finish;
  end

  task automatic send_beat(input logic [2:0] o, input rgbled_pkg::pattern_t p,
                           input rgbled_pkg::color_t c, input logic [23:0] ms);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= o;
    pattern_code <= p;
    color_code   <= c;
    flash_ms     <= ms;
    do @(posedge clk); while (!in_ready);
    op_count[o]++;
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_beat(rgbled_pkg::OP_TICK, rgbled_pkg::pattern_t'($urandom_range(7)),
                         rgbled_pkg::color_t'($urandom_range(7)), 24'($urandom));
  endtask

  task automatic pause_until_drained;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input rgbled_pkg::reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits are random; the engine must only keep the field bits.
  task automatic apply_settings(input logic [MS_W-1:0] refresh, input logic [MS_W-1:0] conn,
                                input logic [MS_W-1:0] alert, input logic [7:0] blue);
    logic [31:0] word;
    pause_until_drained();
    word = $urandom; word[MS_W-1:0] = refresh; write_reg(rgbled_pkg::REG_REFRESH_MS, word);
    word = $urandom; word[MS_W-1:0] = conn;    write_reg(rgbled_pkg::REG_CONNECT_HALF_MS, word);
    word = $urandom; word[MS_W-1:0] = alert;   write_reg(rgbled_pkg::REG_ALERT_HALF_MS, word);
    word = $urandom; word[7:0] = blue;         write_reg(rgbled_pkg::REG_IDLE_BLUE, word);
  endtask

  task automatic random_beat(output logic counted);
    int unsigned pick;
    int unsigned len_sel;
    logic [2:0]  o;
    logic [23:0] ms;
    pick = $urandom_range(99);
    if (pick < 58)      o = rgbled_pkg::OP_TICK;
    else if (pick < 68) o = rgbled_pkg::OP_SET_PATTERN;
    else if (pick < 77) o = rgbled_pkg::OP_FLASH_PAT;
    else if (pick < 84) o = rgbled_pkg::OP_SET_COLOR;
    else if (pick < 93) o = rgbled_pkg::OP_FLASH_COLOR;
    else                o = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    // Mostly short flashes so they end within the run; now and then a long one.
    len_sel = $urandom_range(9);
    if (len_sel < 7)       ms = 24'($urandom_range(30));
    else if (len_sel == 7) ms = 24'($urandom);
    else if (len_sel == 8) ms = '0;
    else                   ms = rgbled_pkg::FLASH_MAX;
    send_beat(o, rgbled_pkg::pattern_t'($urandom_range(7)),
              rgbled_pkg::color_t'($urandom_range(7)), ms);
    counted = (o <= rgbled_pkg::OP_FLASH_COLOR);
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned done_beats;
    logic counted;
    done_beats = 0;
    while (done_beats < n) begin
      random_beat(counted);
      if (counted) done_beats++;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part: reset settings first, then the corner cases one by one.
    send_beat(rgbled_pkg::OP_TICK, rgbled_pkg::PAT_IDLE, rgbled_pkg::COL_OFF, '0);
    apply_settings(10'd1023, rgbled_pkg::CONNECT_HALF_MS_RST, rgbled_pkg::ALERT_HALF_MS_RST,
                   rgbled_pkg::IDLE_BLUE_RST);
    send_beat(rgbled_pkg::OP_TICK, rgbled_pkg::PAT_ERROR, rgbled_pkg::COL_WHITE,
              rgbled_pkg::FLASH_MAX);
    apply_settings(10'd0, 10'd0, 10'd1, 8'd255);
    send_beat(rgbled_pkg::OP_TICK, rgbled_pkg::PAT_IDLE, rgbled_pkg::COL_OFF, '0);
    send_beat(rgbled_pkg::OP_SET_PATTERN, rgbled_pkg::PAT_IDLE, rgbled_pkg::COL_OFF, '0);
    send_beat(rgbled_pkg::OP_SET_PATTERN, rgbled_pkg::PAT_CONNECTING, rgbled_pkg::COL_OFF, '0);
    send_ticks(2);
    send_beat(rgbled_pkg::OP_SET_PATTERN, rgbled_pkg::PAT_EMERGENCY, rgbled_pkg::COL_OFF, '0);
    send_ticks(1);
    send_beat(rgbled_pkg::OP_SET_PATTERN, rgbled_pkg::PAT_ERROR, rgbled_pkg::COL_OFF, '0);
    send_beat(rgbled_pkg::OP_FLASH_PAT, rgbled_pkg::PAT_SCANNING, rgbled_pkg::COL_OFF, 24'd2);
    send_ticks(2);
    send_beat(rgbled_pkg::OP_FLASH_PAT, rgbled_pkg::PAT_RX, rgbled_pkg::COL_OFF, '0);
    send_ticks(1);
    send_beat(rgbled_pkg::OP_FLASH_COLOR, rgbled_pkg::PAT_IDLE, rgbled_pkg::COL_MAGENTA, 24'd2);
    send_ticks(3);
    send_beat(rgbled_pkg::OP_SET_COLOR, rgbled_pkg::PAT_IDLE, rgbled_pkg::COL_WHITE, '0);
    send_ticks(1);
    send_beat(OP_SPARE_LO, rgbled_pkg::PAT_TX, rgbled_pkg::COL_CYAN, 24'd5);
    send_beat(OP_SPARE_HI, rgbled_pkg::PAT_CONNECTED, rgbled_pkg::COL_GREEN, 24'd7);
    send_beat(rgbled_pkg::OP_FLASH_PAT, rgbled_pkg::PAT_TX, rgbled_pkg::COL_OFF,
              rgbled_pkg::FLASH_MAX);
    send_ticks(1);

    // Random phase with the sender idling less than the receiver.
    apply_settings(10'($urandom_range(3)), 10'($urandom_range(1, 6)), 10'd0,
                   8'($urandom_range(255)));
    send_idle_pct = 38;
    recv_idle_pct = 58;
    run_random(BEATS_PER_PHASE);

    // Roles swapped, long blink periods, and a full drain halfway through.
    apply_settings(10'd1, 10'd1023, 10'd1023, 8'd0);
    send_idle_pct = 58;
    recv_idle_pct = 38;
    run_random(BEATS_PER_PHASE / 2);
    pause_until_drained();
    run_random(BEATS_PER_PHASE - BEATS_PER_PHASE / 2);

    // Leave the blink phase past the period that the next settings give it.
    send_beat(rgbled_pkg::OP_SET_PATTERN, rgbled_pkg::PAT_CONNECTED, rgbled_pkg::COL_OFF, '0);
    send_beat(rgbled_pkg::OP_SET_PATTERN, rgbled_pkg::PAT_CONNECTING, rgbled_pkg::COL_OFF, '0);
    send_beat(rgbled_pkg::OP_FLASH_PAT, rgbled_pkg::PAT_CONNECTING, rgbled_pkg::COL_OFF, '0);
    send_ticks(12);
    apply_settings(10'd0, 10'd3, 10'($urandom_range(1, 4)), 8'd255);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_ticks(3);
    run_random(BEATS_PER_PHASE);

    // The rising part of the breathing wave with a refresh on every tick.
    send_beat(rgbled_pkg::OP_SET_PATTERN, rgbled_pkg::PAT_IDLE, rgbled_pkg::COL_OFF, '0);
    send_beat(rgbled_pkg::OP_SET_PATTERN, rgbled_pkg::PAT_SCANNING, rgbled_pkg::COL_OFF, '0);
    send_beat(rgbled_pkg::OP_FLASH_PAT, rgbled_pkg::PAT_SCANNING, rgbled_pkg::COL_OFF, '0);
    send_ticks(SWEEP_TICKS);

    pause_until_drained();
    repeat (3) @(posedge clk);

    for (int i = OP_SPARE_LO; i <= OP_SPARE_HI; i++) spare_ops += op_count[i];
    $display("Sent %0d ticks, %0d pattern sets, %0d pattern flashes, %0d color sets,",
             op_count[rgbled_pkg::OP_TICK], op_count[rgbled_pkg::OP_SET_PATTERN],
             op_count[rgbled_pkg::OP_FLASH_PAT], op_count[rgbled_pkg::OP_SET_COLOR]);
    $display("%0d color flashes and %0d unused ops; checked %0d results (%0d refreshes)",
             op_count[rgbled_pkg::OP_FLASH_COLOR], spare_ops, results_seen, refresh_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("rgb_status_led_pattern_engine_top test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("rgb_status_led_pattern_engine_top test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/rgbled_pkg.sv
design/rgbled_cfg.sv
design/rgbled_breathe.sv
design/rgb_status_led_pattern_engine_top.sv
verif/rgb_led_result_checker.sv
verif/rgb_status_led_pattern_engine_top_tb.sv
